/* rtl/swg_pkg.sv */
// Package: shared constants, types and quarter-wave sine table for the waveform generator.
package swg_pkg;

  localparam int unsigned QUARTER      = 256;
  localparam int unsigned QUARTER_LOG2 = 8;
  localparam int unsigned QIDX_W       = 9;
  localparam logic [15:0] ONE_Q14 = 16'd16384;
  localparam logic [24:0] ONE_Q24 = 25'd16777216;

  localparam logic [2:0] WAVE_ZERO   = 3'd0;
  localparam logic [2:0] WAVE_DELTA  = 3'd1;
  localparam logic [2:0] WAVE_BOXCAR = 3'd2;
  localparam logic [2:0] WAVE_TRI    = 3'd3;
  localparam logic [2:0] WAVE_SINE   = 3'd4;
  localparam logic [2:0] WAVE_DAMPED = 3'd5;

  localparam logic [2:0] REG_WAVE  = 3'd0;
  localparam logic [2:0] REG_START = 3'd1;
  localparam logic [2:0] REG_WIDTH = 3'd2;
  localparam logic [2:0] REG_LEN   = 3'd3;
  localparam logic [2:0] REG_STEP  = 3'd4;
  localparam logic [2:0] REG_DECAY = 3'd5;

  // Classified item handed from front to back.
  typedef struct packed {
    logic [2:0]  wave;
    logic        in_shape;
    logic [15:0] d;
    logic [15:0] w;
    logic [14:0] half;
    logic [31:0] phase;
    logic [24:0] env;
    logic [15:0] index;
    logic        last;
  } job_t;

  typedef logic [QUARTER:0][14:0] sine_tab_t;

  // Long division used only while the table is built.
  function automatic logic [63:0] series_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Table built at elaboration from an integer sine series.
  function automatic logic [14:0] sine_entry(input int unsigned k);
    logic [63:0] x, x2, t, s, v;
    logic [63:0] divs [6];
    divs[0] = 64'd156; divs[1] = 64'd110; divs[2] = 64'd72;
    divs[3] = 64'd42;  divs[4] = 64'd20;  divs[5] = 64'd6;
    x  = (64'd3373259426 * 64'(k)) >> (QUARTER_LOG2 + 1);
    x2 = (x * x) >> 30;
    t  = 64'd1073741824;
    for (int n = 0; n < 6; n++) begin
      t = 64'd1073741824 - series_div((x2 * t) >> 30, divs[n]);
    end
    s = (x * t) >> 30;
    v = (s * 64'd16384 + 64'd536870912) >> 30;
    if (v > 64'd16384) v = 64'd16384;
    return v[14:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int k = 0; k <= QUARTER; k++) tab[k] = sine_entry(k);
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

/* rtl/swg_front.sv */
// Front end: config registers, sample counter, phase and envelope, classification.
module swg_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_addr_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                restart_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output swg_pkg::job_t       job_o
);
  import swg_pkg::*;

  logic [2:0]  wave_q;
  logic [15:0] start_q, width_q, len_q;
  logic [31:0] step_q;
  logic [23:0] decay_q;
  logic [15:0] cnt_q;
  logic [31:0] acc_q;
  logic [24:0] env_q;
  // envelope multiply is registered: one item in flight at a time
  logic        busy_q;
  logic        upd_q;
  logic [24:0] env_mul_q;
  logic        vld_q;
  job_t        job_q;

  logic [15:0] i;
  logic [31:0] ph;
  logic [24:0] ev;
  logic        in_shape, last;
  logic [15:0] d, w;
  logic [16:0] ip1;
  logic        acc_in;
  job_t        j;

  assign in_ready_o = !busy_q && !vld_q;
  assign acc_in     = in_valid_i && in_ready_o;

  always_comb begin
    i  = restart_i ? 16'd0 : cnt_q;
    ph = restart_i ? 32'd0 : acc_q;
    ev = restart_i ? ONE_Q24 : env_q;
    in_shape = i >= start_q;
    d  = i - start_q;
    w  = width_q | 16'd1;
    ip1 = {1'b0, i} + 17'd1;
    last = (len_q == 16'd0) ? (ip1 >= 17'h10000) : (ip1 >= {1'b0, len_q});
    if (wave_q == WAVE_DAMPED && in_shape && d == 16'd0) begin
      ph = 32'd0;
      ev = ONE_Q24;
    end
    j.wave = wave_q; j.in_shape = in_shape; j.d = d; j.w = w; j.half = w[15:1];
    j.phase = ph; j.env = ev; j.index = i; j.last = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= WAVE_ZERO; start_q <= '0; width_q <= 16'd1; len_q <= 16'd1024;
      step_q <= '0; decay_q <= '0;
      cnt_q <= '0; acc_q <= '0; env_q <= ONE_Q24;
      busy_q <= 1'b0; upd_q <= 1'b0; vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_WAVE:  wave_q  <= cfg_data_i[2:0];
          REG_START: start_q <= cfg_data_i[15:0];
          REG_WIDTH: width_q <= cfg_data_i[15:0];
          REG_LEN:   len_q   <= cfg_data_i[15:0];
          REG_STEP:  step_q  <= cfg_data_i;
          REG_DECAY: decay_q <= cfg_data_i[23:0];
          default: ;
        endcase
      end
      if (vld_q && job_ready_i) vld_q <= 1'b0;
      if (acc_in) begin
        vld_q  <= 1'b1;
        busy_q <= 1'b1;
        upd_q  <= !last;
        if (last) begin
          cnt_q <= '0; acc_q <= '0;
        end else begin
          cnt_q <= ip1[15:0];
          acc_q <= ph + step_q;
        end
      end else if (busy_q) begin
        busy_q <= 1'b0;
        env_q  <= upd_q ? env_mul_q : ONE_Q24;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      job_q     <= j;
      env_mul_q <= 25'((49'(ev) * 49'(decay_q)) >> 24);
    end
  end

  assign job_valid_o = vld_q;
  assign job_o       = job_q;

  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !in_ready_o) else $error("accepted while envelope pending");
  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_in |=> busy_q) else $error("busy not set");
  a_env_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    env_q <= ONE_Q24) else $error("envelope above one");
endmodule

/* rtl/swg_fifo.sv */
// Two-entry queue carrying classified items between front and back.
module swg_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  swg_pkg::job_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output swg_pkg::job_t rd_data_o
);
  import swg_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count overflow");
endmodule

/* rtl/swg_divider.sv */
// Radix-2 restoring divider: floor(num*16384/den), one quotient bit a cycle.
module swg_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] num_i,
  input  logic [14:0] den_i,
  output logic        done_o,
  output logic [15:0] quot_o
);
  import swg_pkg::*;

  logic [29:0] dvd_q;
  logic [15:0] rem_q;
  logic [14:0] den_q;
  logic [29:0] quo_q;
  logic [4:0]  cnt_q;
  logic        run_q;
  logic [15:0] trial;
  logic        ge;

  assign trial = {rem_q[14:0], dvd_q[29]};
  assign ge    = {1'b0, trial} >= {2'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1; cnt_q <= 5'd30;
    end else if (run_q) begin
      cnt_q <= cnt_q - 5'd1;
      if (cnt_q == 5'd1) run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {num_i, 14'd0}; rem_q <= '0; den_q <= den_i; quo_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[28:0], 1'b0};
      rem_q <= ge ? trial - {1'b0, den_q} : trial;
      quo_q <= {quo_q[28:0], ge};
    end
  end

  assign done_o = run_q && cnt_q == 5'd0 ? 1'b0 : (!run_q && cnt_q == 5'd0);
  assign quot_o = quo_q[15:0];
endmodule

/* rtl/swg_back.sv */
// Back end: shape evaluation (sine table, envelope multiply, ramp divide) and output register.
module swg_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  swg_pkg::job_t job_i,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [31:0]   m_axis_tdata,
  output logic          m_axis_tlast
);
  import swg_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]  st_q;
  job_t        job_q;
  logic        neg_q;
  logic [14:0] mag_q;
  logic        div_start;
  logic        div_done;
  logic        div_seen_q;
  logic [15:0] quot;
  logic [15:0] val_q;
  logic        ovld_q, ovld_d;
  logic        out_fire;
  logic [15:0] oval_q, oidx_q;
  logic        olast_q;

  logic [1:0]        quad;
  logic [QIDX_W-1:0] jidx, tidx;
  logic [14:0]       tv;
  logic [15:0]       dnum;
  logic [39:0]       prod;
  logic [15:0]       shape;
  logic              use_div;

  always_comb begin
    quad = job_i.phase[31:30];
    jidx = {1'b0, job_i.phase[29:22]};
    tidx = quad[0] ? QIDX_W'(QUARTER) - jidx : jidx;
    tv   = SINE_TAB[tidx];
    shape = '0;
    use_div = 1'b0;
    case (job_i.wave)
      WAVE_DELTA:  if (job_i.in_shape && job_i.d == 16'd0) shape = ONE_Q14;
      WAVE_BOXCAR: if (job_i.in_shape && job_i.d < job_i.w) shape = ONE_Q14;
      WAVE_TRI: begin
        if (job_i.in_shape && job_i.d < job_i.w) begin
          if ({1'b0, job_i.half} == job_i.d) shape = ONE_Q14;
          else use_div = 1'b1;
        end
      end
      WAVE_SINE:   shape = quad[1] ? -{1'b0, tv} : {1'b0, tv};
      default:     shape = '0;
    endcase
    dnum = (job_i.d < {1'b0, job_i.half}) ? job_i.d : job_i.w - 16'd1 - job_i.d;
  end

  assign job_ready_o = st_q == S_IDLE;
  assign div_start   = job_valid_i && job_ready_o && use_div;
  assign prod        = 40'(mag_q) * 40'(job_q.env);
  assign out_fire    = st_q == S_OUT && (!ovld_q || m_axis_tready);
  assign ovld_d      = out_fire || (ovld_q && !m_axis_tready);

  swg_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (dnum),
    .den_i   (job_i.half),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ovld_q <= 1'b0; div_seen_q <= 1'b0;
    end else begin
      ovld_q <= ovld_d;
      case (st_q)
        S_IDLE: if (job_valid_i && job_ready_o) begin
          if (job_i.wave == WAVE_DAMPED && job_i.in_shape) st_q <= S_MUL;
          else if (use_div) begin st_q <= S_DIV; div_seen_q <= 1'b0; end
          else st_q <= S_OUT;
        end
        S_MUL: st_q <= S_OUT;
        S_DIV: begin
          div_seen_q <= 1'b1;
          if (div_seen_q && div_done) st_q <= S_OUT;
        end
        S_OUT: if (out_fire) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) begin
      job_q <= job_i;
      neg_q <= quad[1];
      mag_q <= tv;
      val_q <= (job_i.wave == WAVE_DAMPED) ? 16'd0 : shape;
    end
    if (st_q == S_MUL) val_q <= neg_q ? -prod[39:24] : prod[39:24];
    if (st_q == S_DIV && div_seen_q && div_done) val_q <= quot;
    if (out_fire) begin
      oval_q <= val_q; oidx_q <= job_q.index; olast_q <= job_q.last;
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {oidx_q, oval_q};
  assign m_axis_tlast  = olast_q;

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != S_IDLE |-> !job_ready_o) else $error("job taken while busy");
  a_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_MUL |=> st_q == S_OUT) else $error("multiply step skipped");
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_OUT && !ovld_q) |=> ovld_q) else $error("result lost");
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> st_q == S_DIV) else $error("divider start");
endmodule

/* rtl/synthetic_waveform_generator.sv */
// Top level of the synthetic waveform generator.
// Usage:
//  s_axis carries one word per sample request; bit 0 of tdata is restart.
//  m_axis returns one word per request: tdata[15:0] sample_value (Q1.14),
//  tdata[31:16] sample_index, tlast marks the final sample of the trace.
//  Registers are written through cfg_we_i / cfg_addr_i / cfg_data_i while idle.
// Sample flow:
//  The front takes one request at a time and not the next until its envelope
//  multiply is registered and the item has been passed on. The back handles
//  one sample at a time: zeros, delta, boxcar and sine go straight to the
//  output state, damped sine passes a multiply state first, and a triangle
//  ramp sample waits in a divide state for the bit-serial ramp divider.
//  tvalid rises once the output state has registered the word.
// Reset:
//  Index, phase and envelope return to 0, 0 and 1.0; registers to defaults.
// Stall:
//  A held output word stalls the back end; the two-entry queue then fills and
//  s_axis_tready drops until the receiver takes the word.
module synthetic_waveform_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [0] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [15:0] sample_value, [31:16] sample_index
  output logic        m_axis_tlast
);
  import swg_pkg::*;

  job_t f_job, q_job;
  logic f_vld, f_rdy, q_vld, q_rdy;

  swg_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_data_i,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready),
    .restart_i  (s_axis_tdata[0]),
    .job_valid_o (f_vld), .job_ready_i (f_rdy), .job_o (f_job)
  );

  swg_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i (f_vld), .wr_ready_o (f_rdy), .wr_data_i (f_job),
    .rd_valid_o (q_vld), .rd_ready_i (q_rdy), .rd_data_o (q_job)
  );

  swg_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i (q_vld), .job_ready_o (q_rdy), .job_i (q_job),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );
endmodule
